>>> hw/rtl/tts_pkg.sv
package tts_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int TAB_PITCH   = 8;
    localparam int WIDTH_FLOOR = 10;
    localparam int COL_LIMIT   = 256;
    localparam int RESET_WIDTH = 80;

    localparam int CMD_W = 3;
    localparam int COL_W = 8;
    localparam int WID_W = 9;

    localparam int ROWS  = MAX_COLUMNS / TAB_PITCH;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_W = $clog2(TAB_PITCH);
    localparam int POS_W = ROW_W + BIT_W;
    localparam int EXT_W = (($clog2(MAX_COLUMNS + 1) > WID_W)
                            ? $clog2(MAX_COLUMNS + 1) : WID_W) + 1;
    localparam int WCAP  = (MAX_COLUMNS < COL_LIMIT) ? MAX_COLUMNS : COL_LIMIT;

    localparam logic [CMD_W-1:0] CMD_RESET = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREV  = 3'd4;

    typedef logic [EXT_W-1:0]     t_ext;
    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [TAB_PITCH-1:0] t_byte;

    typedef struct packed {
        logic             dir_up;
        logic             first;
        logic [BIT_W-1:0] bound;
        t_byte            bits;
    } t_srch_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_srch_rsp;

    // saturate the programmed width to the usable range
    function automatic t_ext eff_width(logic [WID_W-1:0] w);
        t_ext x;
        x = t_ext'(w);
        if (x < t_ext'(WIDTH_FLOOR)) begin
            x = t_ext'(WIDTH_FLOOR);
        end
        if (x > t_ext'(WCAP)) begin
            x = t_ext'(WCAP);
        end
        return x;
    endfunction

    // default contents of a row: a stop at its first column if that lies below the width
    function automatic t_byte default_row(t_row row, t_ext w);
        t_byte b;
        b    = '0;
        b[0] = (t_ext'({row, {BIT_W{1'b0}}}) < w);
        return b;
    endfunction

endpackage

>>> hw/rtl/tts_if.sv
interface tts_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::CMD_W-1:0]  cmd;
    logic [tts_pkg::COL_W-1:0]  column;

    modport source (output valid, output cmd, output column, input ready);
    modport sink   (input valid, input cmd, input column, output ready);
endinterface

interface tts_res_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::COL_W-1:0]  target_column;

    modport source (output valid, output target_column, input ready);
    modport sink   (input valid, input target_column, output ready);
endinterface

interface tts_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::WID_W-1:0]  col_count;

    modport source (output valid, output col_count, input ready);
    modport sink   (input valid, input col_count, output ready);
endinterface

>>> hw/rtl/tts_ram.sv
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tts_row_search.sv
module tts_row_search (
    input  tts_pkg::t_srch_req i_req,
    output tts_pkg::t_srch_rsp o_rsp
);

    always_comb begin
        tts_pkg::t_byte            masked;
        logic [tts_pkg::BIT_W-1:0] idx;
        masked = '0;
        idx    = '0;
        for (int k = 0; k < tts_pkg::TAB_PITCH; k++) begin
            if (!i_req.first) begin
                masked[k] = i_req.bits[k];
            end else if (i_req.dir_up) begin
                masked[k] = i_req.bits[k] && (tts_pkg::BIT_W'(k) >= i_req.bound);
            end else begin
                masked[k] = i_req.bits[k] && (tts_pkg::BIT_W'(k) <= i_req.bound);
            end
        end
        // upward search keeps the lowest hit, downward the highest
        if (i_req.dir_up) begin
            for (int k = tts_pkg::TAB_PITCH - 1; k >= 0; k--) begin
                if (masked[k]) begin
                    idx = tts_pkg::BIT_W'(k);
                end
            end
        end else begin
            for (int k = 0; k < tts_pkg::TAB_PITCH; k++) begin
                if (masked[k]) begin
                    idx = tts_pkg::BIT_W'(k);
                end
            end
        end
        o_rsp.found = |masked;
        o_rsp.idx   = idx;
    end

endmodule

>>> hw/rtl/terminal_tab_stop_table.sv
// An accepted reset, set, clear or undefined command completes in its first work state.
// A query scans the stop map one 8-column row per cycle through a single row search unit:
// it ends at the first row with a hit or at the end of the map, after at most ROWS rows
// (32 for 256 columns). One item is in work at a time; the next is taken at the edge after
// the result is loaded, and work holds while the output stalls.
// Reset: width returns to 80, stops lie at every multiple of 8 below 80, no clearing pass.
module terminal_tab_stop_table (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tts_cmd_if.sink   i_cmd,
    tts_cfg_if.sink   i_cfg,
    tts_res_if.source o_res
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_WORK = 1'b1;

    logic [0:0]                  r_state, n_state;
    logic [tts_pkg::CMD_W-1:0]   r_cmd;
    logic [tts_pkg::COL_W-1:0]   r_col;
    logic                        r_inmap;
    logic                        r_first, n_first;
    logic [tts_pkg::BIT_W-1:0]   r_bound;
    tts_pkg::t_row               r_row, n_row;
    logic [tts_pkg::ROWS-1:0]    r_valid;
    tts_pkg::t_ext               r_def_w;
    logic [tts_pkg::WID_W-1:0]   r_width;
    logic                        r_out_valid;
    logic [tts_pkg::COL_W-1:0]   r_out_col;

    logic                        in_acc;
    logic                        out_free;
    logic                        done;
    logic [tts_pkg::COL_W-1:0]   result;
    logic                        ram_we;
    tts_pkg::t_byte              rd_data;
    tts_pkg::t_byte              cur_bits;
    tts_pkg::t_byte              wr_bits;
    tts_pkg::t_srch_req          srch_req;
    tts_pkg::t_srch_rsp          srch_rsp;

    tts_pkg::t_ext               col_ext;
    tts_pkg::t_ext               nxt_ext;
    tts_pkg::t_ext               prv_lim;
    tts_pkg::t_ext               prv_ext;
    logic                        acc_inmap;
    tts_pkg::t_row               acc_row;
    logic [tts_pkg::BIT_W-1:0]   acc_bound;

    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.target_column = r_out_col;

    // starting row and bound of the command being accepted
    always_comb begin
        col_ext   = tts_pkg::t_ext'(i_cmd.column);
        nxt_ext   = col_ext + tts_pkg::t_ext'(1);
        prv_lim   = (col_ext > tts_pkg::t_ext'(tts_pkg::MAX_COLUMNS))
                    ? tts_pkg::t_ext'(tts_pkg::MAX_COLUMNS) : col_ext;
        prv_ext   = prv_lim - tts_pkg::t_ext'(1);
        acc_inmap = 1'b0;
        acc_row   = '0;
        acc_bound = '0;
        unique case (i_cmd.cmd)
            tts_pkg::CMD_SET, tts_pkg::CMD_CLEAR: begin
                acc_inmap = col_ext < tts_pkg::t_ext'(tts_pkg::MAX_COLUMNS);
                acc_row   = tts_pkg::ROW_W'(col_ext >> tts_pkg::BIT_W);
                acc_bound = col_ext[tts_pkg::BIT_W-1:0];
            end
            tts_pkg::CMD_NEXT: begin
                acc_inmap = nxt_ext < tts_pkg::t_ext'(tts_pkg::MAX_COLUMNS);
                acc_row   = tts_pkg::ROW_W'(nxt_ext >> tts_pkg::BIT_W);
                acc_bound = nxt_ext[tts_pkg::BIT_W-1:0];
            end
            tts_pkg::CMD_PREV: begin
                acc_inmap = prv_lim != '0;
                acc_row   = tts_pkg::ROW_W'(prv_ext >> tts_pkg::BIT_W);
                acc_bound = prv_ext[tts_pkg::BIT_W-1:0];
            end
            default: begin
                acc_inmap = 1'b0;
            end
        endcase
    end

    // a row never written since the last reset reads as its default
    assign cur_bits = r_valid[r_row] ? rd_data : tts_pkg::default_row(r_row, r_def_w);

    always_comb begin
        wr_bits = cur_bits;
        wr_bits[r_bound] = (r_cmd == tts_pkg::CMD_SET);
    end

    assign srch_req.dir_up = (r_cmd == tts_pkg::CMD_NEXT);
    assign srch_req.first  = r_first;
    assign srch_req.bound  = r_bound;
    assign srch_req.bits   = cur_bits;

    tts_row_search u_search (
        .i_req (srch_req),
        .o_rsp (srch_rsp)
    );

    // sequencer: decide completion, result and the next row to fetch
    always_comb begin
        done    = 1'b0;
        result  = r_col;
        n_row   = r_row;
        n_first = r_first;
        n_state = r_state;
        if (r_state == S_IDLE) begin
            if (in_acc) begin
                n_row   = acc_row;
                n_first = 1'b1;
                n_state = S_WORK;
            end
        end else begin
            case (r_cmd)
                tts_pkg::CMD_NEXT: begin
                    if (!r_inmap) begin
                        done   = 1'b1;
                        result = tts_pkg::COL_W'(tts_pkg::eff_width(r_width)
                                 - tts_pkg::t_ext'(1));
                    end else if (srch_rsp.found) begin
                        done   = 1'b1;
                        result = tts_pkg::COL_W'({r_row, srch_rsp.idx});
                    end else if (r_row == tts_pkg::ROW_W'(tts_pkg::ROWS - 1)) begin
                        done   = 1'b1;
                        result = tts_pkg::COL_W'(tts_pkg::eff_width(r_width)
                                 - tts_pkg::t_ext'(1));
                    end else begin
                        n_row   = r_row + tts_pkg::ROW_W'(1);
                        n_first = 1'b0;
                    end
                end
                tts_pkg::CMD_PREV: begin
                    if (!r_inmap) begin
                        done   = 1'b1;
                        result = '0;
                    end else if (srch_rsp.found) begin
                        done   = 1'b1;
                        result = tts_pkg::COL_W'({r_row, srch_rsp.idx});
                    end else if (r_row == '0) begin
                        done   = 1'b1;
                        result = '0;
                    end else begin
                        n_row   = r_row - tts_pkg::ROW_W'(1);
                        n_first = 1'b0;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done && out_free) begin
                n_state = S_IDLE;
            end
        end
    end

    assign ram_we = (r_state == S_WORK) && r_inmap && out_free
                    && ((r_cmd == tts_pkg::CMD_SET) || (r_cmd == tts_pkg::CMD_CLEAR));

    tts_ram #(
        .WIDTH (tts_pkg::TAB_PITCH),
        .DEPTH (tts_pkg::ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (wr_bits),
        .i_raddr (n_row),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_row       <= '0;
            r_valid     <= '0;
            r_def_w     <= tts_pkg::t_ext'(tts_pkg::RESET_WIDTH);
            r_width     <= tts_pkg::WID_W'(tts_pkg::RESET_WIDTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_row   <= n_row;
            if (i_cfg.valid && i_cfg.ready) begin
                r_width <= i_cfg.col_count;
            end
            if (ram_we) begin
                r_valid[r_row] <= 1'b1;
            end
            // reload defaults: drop every written row and latch the width
            if ((r_state == S_WORK) && (r_cmd == tts_pkg::CMD_RESET) && out_free) begin
                r_valid <= '0;
                r_def_w <= tts_pkg::eff_width(r_width);
            end
            if ((r_state == S_WORK) && done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd.cmd;
            r_col   <= i_cmd.column;
            r_inmap <= acc_inmap;
            r_bound <= acc_bound;
        end
        if ((r_state == S_WORK) && done && out_free) begin
            r_out_col <= result;
        end
    end

    a_accept_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_WORK))
        else $error("accepted item did not start work");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("stop map written while idle");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WORK) && (r_cmd == tts_pkg::CMD_RESET) && out_free)
        |=> (r_valid == '0))
        else $error("reset command left written rows valid");

    a_scan_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WORK) && !r_first)
        |-> ((r_cmd == tts_pkg::CMD_NEXT) || (r_cmd == tts_pkg::CMD_PREV)))
        else $error("row scan advanced for a non-query command");

endmodule
